// ===== rtl/bcc_pkg.sv =====
package bcc_pkg;

    // Default width of the tick counter.
    localparam int COUNT_WIDTH_DEF = 10;

    // Width of the two tick limit registers.
    localparam int LIMIT_W = 10;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = LIMIT_W;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_WINDOW = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESSED_LEVEL = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [LIMIT_W-1:0] LONG_PRESS_RESET    = 10'd50;
    localparam logic [LIMIT_W-1:0] DOUBLE_WINDOW_RESET = 10'd10;
    localparam logic               PRESSED_LEVEL_RESET = 1'b0;

    // Phase codes.
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DEBOUNCE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PRESSED  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LONG     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WAIT     = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SECOND   = 3'd5;

    // Click event codes.
    localparam int EVENT_W = 2;
    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_SINGLE = 2'd1;
    localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;
    localparam logic [EVENT_W-1:0] EV_LONG   = 2'd3;

    typedef struct packed {
        logic [LIMIT_W-1:0] long_press_ticks;
        logic [LIMIT_W-1:0] double_window_ticks;
        logic               pressed_level;
    } bcc_cfg_t;

endpackage

// ===== rtl/bcc_cfg.sv =====
module bcc_cfg
    import bcc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output bcc_cfg_t               cfg
);

    bcc_cfg_t cfg_reg;

    // Writes to an index beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks    <= LONG_PRESS_RESET;
            cfg_reg.double_window_ticks <= DOUBLE_WINDOW_RESET;
            cfg_reg.pressed_level       <= PRESSED_LEVEL_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LONG_PRESS:    cfg_reg.long_press_ticks    <= cfg_data[LIMIT_W-1:0];
                CFG_DOUBLE_WINDOW: cfg_reg.double_window_ticks <= cfg_data[LIMIT_W-1:0];
                CFG_PRESSED_LEVEL: cfg_reg.pressed_level       <= cfg_data[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/bcc_step.sv =====
module bcc_step
    import bcc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  bcc_cfg_t               cfg,
    input  logic                   pin_level,
    input  logic [PHASE_W-1:0]     phase,
    input  logic [COUNT_WIDTH-1:0] tick_count,
    output logic [PHASE_W-1:0]     phase_next,
    output logic [COUNT_WIDTH-1:0] tick_count_next,
    output logic [EVENT_W-1:0]     event_next
);

    // The compare is done at the wider of the counter and the limits, so a limit
    // above the counter's top value is never reached.
    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    logic                   press;
    logic                   long_hit;
    logic                   window_hit;
    logic [COUNT_WIDTH-1:0] count_up;

    assign press      = (pin_level == cfg.pressed_level);
    assign long_hit   = CMP_W'(tick_count) >= CMP_W'(cfg.long_press_ticks);
    assign window_hit = CMP_W'(tick_count) >= CMP_W'(cfg.double_window_ticks);
    assign count_up   = (&tick_count) ? tick_count : tick_count + 1'b1;

    always_comb
    begin
        phase_next      = phase;
        tick_count_next = tick_count;
        event_next      = EV_NONE;
        case (phase)
            PH_IDLE:
            begin
                phase_next = press ? PH_DEBOUNCE : PH_IDLE;
            end
            PH_DEBOUNCE:
            begin
                phase_next = press ? PH_PRESSED : PH_IDLE;
            end
            PH_PRESSED:
            begin
                if (press && long_hit)
                begin
                    phase_next      = PH_LONG;
                    tick_count_next = '0;
                end
                else if (press)
                begin
                    tick_count_next = count_up;
                end
                else
                begin
                    phase_next      = PH_WAIT;
                    tick_count_next = '0;
                end
            end
            PH_LONG:
            begin
                tick_count_next = '0;
                if (!press)
                begin
                    phase_next = PH_IDLE;
                    event_next = EV_LONG;
                end
            end
            PH_WAIT:
            begin
                if (!press && window_hit)
                begin
                    phase_next      = PH_IDLE;
                    tick_count_next = '0;
                    event_next      = EV_SINGLE;
                end
                else if (!press)
                begin
                    tick_count_next = count_up;
                end
                else
                begin
                    phase_next      = PH_SECOND;
                    tick_count_next = '0;
                end
            end
            PH_SECOND:
            begin
                if (press && long_hit)
                begin
                    phase_next      = PH_LONG;
                    tick_count_next = '0;
                    event_next      = EV_SINGLE;
                end
                else if (press)
                begin
                    tick_count_next = count_up;
                end
                else
                begin
                    phase_next      = PH_IDLE;
                    tick_count_next = '0;
                    event_next      = EV_DOUBLE;
                end
            end
            default:
            begin
                phase_next      = PH_IDLE;
                tick_count_next = '0;
            end
        endcase
    end

endmodule

// ===== rtl/button_click_classifier.sv =====
// Push-button click classifier. Each input beat carries one sampled pin level for
// one scan tick, and each one produces exactly one output beat with the click event
// for that tick: none, single, double or long press. A six-phase state machine
// (idle, debounce, pressed, long held, waiting for a second press, second press)
// counts ticks against the long-press limit and the double-click window, both set
// through the configuration port together with the pin level that means pressed.
// Long presses are reported on release; a second press held to the long limit
// reports a single click at once and then behaves as a long hold. The tick counter
// saturates at its top value. The phase and counter update is one compare-and-count
// step between the state registers and the output register, so a new beat is
// accepted in every cycle while the output side keeps taking results, and the
// result is registered and appears in the cycle after its beat is accepted.
module button_click_classifier
    import bcc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   pin_level,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [EVENT_W-1:0]     click_event,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    bcc_cfg_t               cfg;
    logic [PHASE_W-1:0]     phase_reg;
    logic [PHASE_W-1:0]     phase_next;
    logic [COUNT_WIDTH-1:0] tick_count_reg;
    logic [COUNT_WIDTH-1:0] tick_count_next;
    logic [EVENT_W-1:0]     event_next;
    logic [EVENT_W-1:0]     event_reg;
    logic                   out_valid_reg;
    logic                   in_accept;

    bcc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcc_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step
    (
        .cfg             (cfg),
        .pin_level       (pin_level),
        .phase           (phase_reg),
        .tick_count      (tick_count_reg),
        .phase_next      (phase_next),
        .tick_count_next (tick_count_next),
        .event_next      (event_next)
    );

    // The output register is the only buffer. It can take a new result whenever it
    // is empty or its current beat leaves in this same cycle, so the input side
    // stalls only while a finished result is held back by the output side.
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    // The phase and counter advance only on an accepted beat, so the state always
    // matches the number of ticks delivered so far.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
        end
        else if (in_accept)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // The event itself is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            event_reg <= event_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign click_event = event_reg;

    // A long press can only be reported when leaving the long held phase.
    a_long_from_long_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (phase_reg != PH_LONG)) |=> (click_event != EV_LONG))
        else $error("long press reported outside the long held phase");

    // A double click can only be reported when leaving the second press phase.
    a_double_from_second: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (phase_reg != PH_SECOND)) |=> (click_event != EV_DOUBLE))
        else $error("double click reported outside the second press phase");

    // The counter is held at zero throughout the long held phase.
    a_long_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (phase_reg == PH_LONG)) |=> (tick_count_reg == '0))
        else $error("tick counter not cleared in the long held phase");

    // State moves only with an accepted beat.
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> ($stable(phase_reg) && $stable(tick_count_reg)))
        else $error("state changed without an accepted beat");

endmodule
